>>> src/pair_sum_exists_assert.svh
// Assertion macros for the pair-sum detector.
`ifndef PAIR_SUM_EXISTS_ASSERT_SVH
`define PAIR_SUM_EXISTS_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pse_pkg.sv
// Package with types and constants for the pair-sum detector.
package pse_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W = 32;

  // One input item: an element and the end-of-set flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic found;
    logic overflow;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_LOAD,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

endpackage

>>> src/pair_sum_exists.sv
// Pair-sum detector: stores a set, then checks every pair with one shared adder.
// Each element is loaded as one input item. After the last item, if two or more
// elements are stored, the scan checks each pair in a read state and a compare state;
// a hit ends it early. The done state then loads the output register once it is free.
// The input stalls from the last item until the result enters the output register.
// Reset (rst_n low, synchronous) clears the sequencer, count, overflow and output-valid flags and target.
`include "pair_sum_exists_assert.svh"

module pair_sum_exists import pse_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_wr_en,
  input  logic signed [DATA_W-1:0] cfg_wr_data
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] target_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic [DATA_W-1:0]        mem [CAPACITY];
  logic [DATA_W-1:0]        rd_a_r, rd_b_r;

  logic                     in_acc;
  logic                     full;
  logic                     wr_en;
  logic [CNT_W-1:0]         n_load;
  logic [DATA_W:0]          sum;
  logic                     match;
  logic                     j_at_end;
  logic [CNT_W-1:0]         i_plus2;
  logic                     i_has_next;
  logic                     out_free;

  // Handshake and shared arithmetic.
  assign in_acc     = in_valid && !in_stall;
  assign full       = (cnt_r == CNT_W'(CAPACITY));
  assign wr_en      = in_acc && !full;
  assign n_load     = full ? cnt_r : cnt_r + CNT_W'(1);
  assign sum        = {rd_a_r[DATA_W-1], rd_a_r} + {rd_b_r[DATA_W-1], rd_b_r};
  assign match      = (sum == {target_r[DATA_W-1], target_r});
  assign j_at_end   = (CNT_W'(j_r) == cnt_r - CNT_W'(1));
  assign i_plus2    = CNT_W'(i_r) + CNT_W'(2);
  assign i_has_next = (i_plus2 < cnt_r);
  assign out_free   = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc && in_data.last) begin
          state_nxt = (n_load >= CNT_W'(2)) ? S_READ : S_DONE;
        end
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (match || (j_at_end && !i_has_next)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Outputs and datapath next values.
  always_comb begin
    in_stall      = (state_r != S_LOAD);
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    found_nxt     = found_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cnt_nxt = n_load;
          ovf_nxt = ovf_r || full;
          if (in_data.last) begin
            found_nxt = 1'b0;
            i_nxt     = '0;
            j_nxt     = IDX_W'(1);
          end
        end
      end
      S_READ: begin
      end
      S_CMP: begin
        if (match) begin
          found_nxt = 1'b1;
        end else if (j_at_end) begin
          i_nxt = i_r + IDX_W'(1);
          j_nxt = i_plus2[IDX_W-1:0];
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.found    = found_r;
          out_nxt.overflow = ovf_r;
          cnt_nxt          = '0;
          ovf_nxt          = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    out_r   <= out_nxt;
  end

  // Element store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= in_data.value;
    end
    if (state_r == S_READ) begin
      rd_a_r <= mem[i_r];
      rd_b_r <= mem[j_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencer and the scan indexes.
  `PSE_ASSERT_NOW(a_no_accept_busy, in_acc, state_r == S_LOAD, "item accepted while busy")
  `PSE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(CAPACITY), "element count past capacity")
  `PSE_ASSERT_NOW(a_pair_distinct, state_r == S_CMP, j_r > i_r && CNT_W'(j_r) < cnt_r, "bad pair")
  `PSE_ASSERT_NEXT(a_out_from_done, state_r != S_DONE, !$rose(out_valid_r), "stray result")

endmodule
